@@ sv/grbf_pkg.sv @@
package grbf_pkg;

  localparam int ElementWidthDef = 16;
  localparam int AccWidthDef     = 48;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_SIGMA = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE  = 2'd1;

  localparam logic [15:0] SIGMA_RST = 16'd256;
  localparam logic [15:0] BASE_RST  = 16'd696;
  localparam logic [15:0] BASE_ONE  = 16'd256;

  localparam int QueueDepth = 2;

  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [3:0]  TAYLOR_LAST = 4'd14;
  localparam logic [11:0] XI_LIMIT_SH = 12'd0;   // x integer limit is 2^12
  localparam logic [4:0]  TI_MAX      = 5'd16;
  localparam logic [16:0] KV_ONE      = 17'd65536;

  // ceil(2^36 / k); exact floor(p / k) for p < 2^32 and k <= 14
  function automatic logic [35:0] recip_k(input logic [3:0] k);
    logic [35:0] r;
    unique case (k)
      4'd2:    r = 36'd34359738368;
      4'd3:    r = 36'd22906492246;
      4'd4:    r = 36'd17179869184;
      4'd5:    r = 36'd13743895348;
      4'd6:    r = 36'd11453246123;
      4'd7:    r = 36'd9817068106;
      4'd8:    r = 36'd8589934592;
      4'd9:    r = 36'd7635497416;
      4'd10:   r = 36'd6871947674;
      4'd11:   r = 36'd6247225158;
      4'd12:   r = 36'd5726623062;
      4'd13:   r = 36'd5286113596;
      4'd14:   r = 36'd4908534053;
      default: r = 36'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/grbf_front.sv @@
module grbf_front #(
  parameter int ELEMENT_WIDTH = grbf_pkg::ElementWidthDef,
  parameter int ACC_WIDTH     = grbf_pkg::AccWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic signed [ELEMENT_WIDTH-1:0] elem_a_i,
  input  logic signed [ELEMENT_WIDTH-1:0] elem_b_i,
  input  logic                            last_i,
  output logic                            q_push_o,
  input  logic                            q_full_i,
  output logic [ACC_WIDTH:0]              q_data_o
);
  import grbf_pkg::*;

  localparam int EW = ELEMENT_WIDTH;
  localparam int AW = ACC_WIDTH;
  localparam int SQW = 2 * EW;
  localparam int SW = ((AW > SQW) ? AW : SQW) + 1;

  logic                v_q, v_d;
  logic                last_q;
  logic [SQW-1:0]      sq_q;
  logic [AW-1:0]       sum_q, sum_d;
  logic                flag_q, flag_d;
  logic signed [EW:0]  diff;
  logic [EW:0]         mag_full;
  logic [EW-1:0]       mag;
  logic [SW-1:0]       sum_ext;
  logic                sat;
  logic [AW-1:0]       sum_new;
  logic                flag_new;
  logic                accept, advance;

  assign diff     = $signed({elem_a_i[EW-1], elem_a_i}) - $signed({elem_b_i[EW-1], elem_b_i});
  assign mag_full = diff[EW] ? (~diff + 1'b1) : diff;
  assign mag      = mag_full[EW-1:0];

  assign advance = v_q && (!last_q || !q_full_i);
  assign full    = v_q && last_q && q_full_i;
  assign accept  = push && !full;

  assign sum_ext  = {{(SW-AW){1'b0}}, sum_q} + {{(SW-SQW){1'b0}}, sq_q};
  assign sat      = |sum_ext[SW-1:AW];
  assign sum_new  = sat ? {AW{1'b1}} : sum_ext[AW-1:0];
  assign flag_new = flag_q | sat;

  assign q_push_o = advance && last_q;
  assign q_data_o = {flag_new, sum_new};

  always_comb begin
    v_d    = v_q;
    sum_d  = sum_q;
    flag_d = flag_q;
    if (advance) begin
      v_d = 1'b0;
      if (last_q) begin
        sum_d  = '0;
        flag_d = 1'b0;
      end else begin
        sum_d  = sum_new;
        flag_d = flag_new;
      end
    end
    if (accept) v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      sum_q  <= '0;
      flag_q <= 1'b0;
    end else begin
      v_q    <= v_d;
      sum_q  <= sum_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q   <= mag * mag;
      last_q <= last_i;
    end
  end

endmodule

@@ sv/grbf_queue.sv @@
module grbf_queue #(
  parameter int WIDTH = grbf_pkg::AccWidthDef + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  import grbf_pkg::*;

  localparam int PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);

  logic [WIDTH-1:0] mem_q [QueueDepth];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= inc(wptr_q);
      if (do_rd) rptr_q <= inc(rptr_q);
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wdata_i;
  end

endmodule

@@ sv/grbf_back.sv @@
module grbf_back #(
  parameter int ACC_WIDTH = grbf_pkg::AccWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        sigma_i,
  input  logic [15:0]        base_i,
  input  logic               q_empty_i,
  input  logic [ACC_WIDTH:0] q_data_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [16:0]        kernel_value_o,
  output logic               overflow_o
);
  import grbf_pkg::*;

  localparam int AW = ACC_WIDTH;
  localparam int DIVW = ((AW + 16) > 61) ? (AW + 16) : 61;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOG   = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_TMUL  = 10'b0000010000,
    S_YMUL  = 10'b0000100000,
    S_PMUL  = 10'b0001000000,
    S_QDIV  = 10'b0010000000,
    S_ROUND = 10'b0100000000,
    S_FINAL = 10'b1000000000
  } state_e;

  state_e          st_q, st_d;
  logic [AW-1:0]   d_q;
  logic            ovf_q;
  logic [31:0]     s2_q;
  logic [2:0]      ip_q;
  logic [30:0]     m_q;
  logic [15:0]     frac_q;
  logic [4:0]      cnt_q;
  logic [DIVW-1:0] rem_q, dsh_q;
  logic [27:0]     x_q;
  logic [15:0]     tf_q;
  logic [4:0]      ti_q;
  logic [31:0]     y_q;
  logic [32:0]     term_q;
  logic [33:0]     acc_q;
  logic [3:0]      k_q;
  logic [31:0]     prod_q;
  logic [16:0]     res_q;
  logic            out_v_q;
  logic [16:0]     out_val_q;
  logic            out_ovf_q;

  // operand preparation
  logic [15:0]     s_eff, b_eff;
  logic [2:0]      ip_c;
  logic [45:0]     m_wide;
  logic [61:0]     msq;
  logic [31:0]     mn;
  logic [18:0]     lb;
  logic [32:0]     den;
  logic [DIVW-1:0] den_lim;
  logic            rem_ge;
  logic [46:0]     tmul;
  logic [47:0]     ymul;
  logic [64:0]     pmul;
  logic [67:0]     qmul;
  logic [31:0]     qk;
  logic [34:0]     rsum;
  logic [34:0]     rsh;
  logic            take;
  logic            out_free;

  assign s_eff = (sigma_i == '0) ? 16'd1 : sigma_i;
  assign b_eff = (base_i < BASE_ONE) ? BASE_ONE : base_i;

  always_comb begin
    ip_c = 3'd0;
    for (int i = 9; i <= 15; i++) begin
      if (b_eff[i]) ip_c = 3'(i - 8);
    end
  end

  assign m_wide  = {30'b0, b_eff} << (5'd22 - {2'b0, ip_c});
  assign msq     = {31'b0, m_q} * {31'b0, m_q};
  assign mn      = msq[61:30];
  assign lb      = {ip_q, frac_q};
  assign den     = {s2_q, 1'b0};
  assign den_lim = {{(DIVW-45){1'b0}}, den, XI_LIMIT_SH};
  assign rem_ge  = (rem_q >= dsh_q);
  assign tmul    = {19'b0, x_q} * {28'b0, lb};
  assign ymul    = {32'b0, tf_q} * {16'b0, LN2_Q32};
  assign pmul    = {32'b0, term_q} * {33'b0, y_q};
  assign qmul    = {36'b0, prod_q} * {32'b0, recip_k(k_q)};
  assign qk      = (k_q == 4'd1) ? prod_q : qmul[67:36];
  assign rsum    = {1'b0, acc_q} + (35'd1 << (6'd15 + {1'b0, ti_q}));
  assign rsh     = rsum >> (6'd16 + {1'b0, ti_q});

  assign out_free = !out_v_q || pop;
  assign take     = (st_q == S_FINAL) && out_free;
  assign q_pop_o  = (st_q == S_IDLE) && !q_empty_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:  if (!q_empty_i) st_d = S_LOG;
      S_LOG:   if (cnt_q == '0) st_d = S_CHECK;
      S_CHECK: begin
        if (lb == '0) st_d = S_FINAL;
        else if ({{(DIVW-AW){1'b0}}, d_q} >= den_lim) st_d = S_FINAL;
        else st_d = S_DIV;
      end
      S_DIV:   if (cnt_q == '0) st_d = S_TMUL;
      S_TMUL:  st_d = (tmul[46:32] > {10'b0, TI_MAX}) ? S_FINAL : S_YMUL;
      S_YMUL:  st_d = S_PMUL;
      S_PMUL:  st_d = S_QDIV;
      S_QDIV:  st_d = (k_q == TAYLOR_LAST) ? S_ROUND : S_PMUL;
      S_ROUND: st_d = S_FINAL;
      S_FINAL: if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (take) out_v_q <= 1'b1;
      else if (pop) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        d_q    <= q_data_i[AW-1:0];
        ovf_q  <= q_data_i[AW];
        s2_q   <= s_eff * s_eff;
        ip_q   <= ip_c;
        m_q    <= m_wide[30:0];
        frac_q <= '0;
        cnt_q  <= 5'd15;
      end
      S_LOG: begin
        // one squaring per fraction bit
        if (mn[31]) m_q <= mn[31:1];
        else m_q <= mn[30:0];
        frac_q <= {frac_q[14:0], mn[31]};
        cnt_q  <= cnt_q - 1'b1;
      end
      S_CHECK: begin
        rem_q <= {{(DIVW-AW-16){1'b0}}, d_q, 16'b0};
        dsh_q <= {{(DIVW-60){1'b0}}, den, 27'b0};
        x_q   <= '0;
        cnt_q <= 5'd27;
        if (lb == '0) res_q <= KV_ONE;
        else res_q <= '0;
      end
      S_DIV: begin
        if (rem_ge) rem_q <= rem_q - dsh_q;
        dsh_q <= dsh_q >> 1;
        x_q   <= {x_q[26:0], rem_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      S_TMUL: begin
        tf_q  <= tmul[31:16];
        ti_q  <= tmul[36:32];
        res_q <= '0;
      end
      S_YMUL: begin
        y_q    <= ymul[47:16];
        term_q <= 33'd1 << 32;
        acc_q  <= 34'd1 << 32;
        k_q    <= 4'd1;
      end
      S_PMUL: prod_q <= pmul[63:32];
      S_QDIV: begin
        term_q <= {1'b0, qk};
        if (k_q[0]) acc_q <= acc_q - {2'b0, qk};
        else acc_q <= acc_q + {2'b0, qk};
        k_q <= k_q + 1'b1;
      end
      S_ROUND: res_q <= rsh[16:0];
      S_FINAL: begin
        if (out_free) begin
          out_val_q <= res_q;
          out_ovf_q <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign empty          = !out_v_q;
  assign kernel_value_o = out_val_q;
  assign overflow_o     = out_ovf_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i) else $error("pop from empty mid queue");

  a_final_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FINAL && !out_v_q) |=> (out_v_q && st_q == S_IDLE))
    else $error("result not loaded from final state");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_QDIV) |-> (k_q != 4'd0 && k_q <= TAYLOR_LAST))
    else $error("series index out of range");

endmodule

@@ sv/gaussian_rbf_kernel_top.sv @@
// Gaussian RBF kernel, streamed.
// Input channel (push/full): one element pair per beat, elem_a_i and
// elem_b_i signed Q8.8; last_i marks the final pair of a vector. A scalar
// distance is sent as elem_a_i with elem_b_i = 0 and last_i = 1.
// Result channel (empty/pop): one beat per vector, kernel_value_o in
// unsigned Q1.16 (65536 = 1.0) and overflow_o when the squared distance
// sum saturated. Config channel (cfg_valid_i/cfg_ready_o) writes sigma
// (index 0) and base (index 1); unknown indexes are dropped. Write only
// when idle.
// Throughput: the accumulator front takes one pair per cycle while full
// is low. Each last pair is queued (2 entries) for the kernel engine,
// which works on one vector at a time: 16 log2 squarings, 28 restoring
// divide steps and 14 series terms, each a multiply and a divide, plus
// load, check, two multiplies, rounding and output; early 1.0 or 0
// results skip the remaining steps.
// When pop is held off the result register and mid queue fill; then full
// rises on the next last pair and the front stalls. Reset clears the sum,
// the overflow flag, queue and result, and sets sigma = 1.0, base = e.
module gaussian_rbf_kernel_top #(
  parameter int ELEMENT_WIDTH = grbf_pkg::ElementWidthDef,
  parameter int ACC_WIDTH     = grbf_pkg::AccWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [grbf_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic signed [ELEMENT_WIDTH-1:0] elem_a_i,
  input  logic signed [ELEMENT_WIDTH-1:0] elem_b_i,
  input  logic                            last_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [16:0]                     kernel_value_o,
  output logic                            overflow_o
);
  import grbf_pkg::*;

  logic [15:0]        sigma_q, base_q;
  logic               q_push, q_full, q_pop, q_empty;
  logic [ACC_WIDTH:0] q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= SIGMA_RST;
      base_q  <= BASE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == REG_SIGMA) sigma_q <= cfg_data_i;
      else if (cfg_addr_i == REG_BASE) base_q <= cfg_data_i;
    end
  end

  grbf_front #(
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .elem_a_i(elem_a_i),
    .elem_b_i(elem_b_i),
    .last_i  (last_i),
    .q_push_o(q_push),
    .q_full_i(q_full),
    .q_data_o(q_wdata)
  );

  grbf_queue #(
    .WIDTH(ACC_WIDTH + 1)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .rd_i   (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  grbf_back #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sigma_i       (sigma_q),
    .base_i        (base_q),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .kernel_value_o(kernel_value_o),
    .overflow_o    (overflow_o)
  );

endmodule
